@@ rtl/lpst_pkg.sv @@
package lpst_pkg;

  localparam int MAX_SLOTS_DEF = 1024;
  localparam int SYMBOL_BYTES = 16;
  localparam int SLOT_W = 10;
  localparam int LEN_W = 5;
  localparam logic [3:0] LG_MIN = 4'd3;
  localparam logic [3:0] LG_MAX = 4'd10;
  localparam logic [3:0] LG_RESET = 4'd10;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
  localparam logic [7:0] CASE_DIFF = 8'h20;

  localparam logic [1:0] REG_SLOT_COUNT_LOG2 = 2'd0;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_PATCH  = 2'd2,
    OP_CLEAR  = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_DUPLICATE = 3'd2,
    ST_FULL      = 3'd3,
    ST_EMPTY_SYM = 3'd4
  } status_t;

  typedef struct packed {
    logic          valid;
    logic [63:0]   hash;
    logic [LEN_W-1:0] len;
    logic [127:0]  sym;
    logic [63:0]   offset;
    logic [63:0]   size;
    logic [31:0]   checksum;
    logic [31:0]   uid;
  } entry_t;

  // Length clipped to the symbol capacity.
  function automatic logic [LEN_W-1:0] canon_len(input logic [LEN_W-1:0] raw);
    canon_len = (raw > LEN_W'(SYMBOL_BYTES)) ? LEN_W'(SYMBOL_BYTES) : raw;
  endfunction

  // Upper-case ASCII letters and zero every byte past the length.
  function automatic logic [127:0] canon_sym(input logic [LEN_W-1:0] len,
                                             input logic [63:0] lo,
                                             input logic [63:0] hi);
    logic [127:0] raw;
    logic [7:0] c;
    raw = {hi, lo};
    canon_sym = '0;
    for (int i = 0; i < 16; i++) begin
      c = raw[i*8 +: 8];
      if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
        c = c - CASE_DIFF;
      end
      if (LEN_W'(i) < len) begin
        canon_sym[i*8 +: 8] = c;
      end
    end
  endfunction

endpackage

@@ rtl/linear_probe_symbol_table.sv @@
// Open-addressed symbol table with linear probing, held in one synchronous
// memory of entry words (valid flag, hash, length, symbol and payload).
// The input channel takes one request word: insert, lookup, checksum patch
// or clear. The output channel returns exactly one result word per request.
// Both channels use valid/ready; a request is taken at an edge where
// in_valid and in_ready are high, a result where out_valid and out_ready are.
// The engine handles one request at a time. The memory is read once per
// cycle with a registered read port, and each probe reads one row. A clear
// writes every memory row once, one row a cycle. After reset the block
// runs the same pass over the memory with in_ready low; configuration
// writes are taken at any time. The result sits in an output register; a
// new request is accepted while it waits, and the engine holds its next
// result until out_ready frees that register, so nothing is lost when the
// receiver stalls.
// slot_count_log2 is clamped to 3..10 and to the memory size.
module linear_probe_symbol_table #(
  parameter int MAX_SLOTS = lpst_pkg::MAX_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic [63:0] in_key_hash,
  input  logic [4:0]  in_symbol_length,
  input  logic [63:0] in_symbol_low,
  input  logic [63:0] in_symbol_high,
  input  logic [63:0] in_entry_offset,
  input  logic [63:0] in_entry_size,
  input  logic [31:0] in_entry_checksum,
  input  logic [31:0] in_entry_uid,
  input  logic [9:0]  in_target_slot,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [9:0]  out_slot_found,
  output logic [63:0] out_found_offset,
  output logic [63:0] out_found_size,
  output logic [31:0] out_found_checksum,
  output logic [31:0] out_found_uid,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import lpst_pkg::*;

  // Slots beyond 1024 are never addressed, so the memory stops there.
  localparam int LG_SLOTS = $clog2(MAX_SLOTS);
  localparam int IDX_W = (LG_SLOTS < 10) ? LG_SLOTS : 10;
  localparam int DEPTH = 1 << IDX_W;
  localparam logic [3:0] IDX_LG = 4'(IDX_W);

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_PROBE, S_PATCH, S_CLEAR, S_FIN
  } state_t;

  state_t state_r, state_nxt;

  // Configuration register.
  logic [3:0] lg_cfg_r;
  logic       cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == {REG_SLOT_COUNT_LOG2, 1'b0});
  assign prdata = (paddr == {REG_SLOT_COUNT_LOG2, 1'b0}) ? {28'd0, lg_cfg_r} : 32'd0;

  // Probe mask from the register.
  logic [3:0] lg_clamp, lg_eff;
  logic [IDX_W-1:0] mask;
  always_comb begin
    lg_clamp = lg_cfg_r;
    if (lg_clamp < LG_MIN) lg_clamp = LG_MIN;
    if (lg_clamp > LG_MAX) lg_clamp = LG_MAX;
    lg_eff = (lg_clamp > IDX_LG) ? IDX_LG : lg_clamp;
    mask = {IDX_W{1'b1}} >> (IDX_LG - lg_eff);
  end

  // Request registers.
  opcode_t          op_r;
  logic [63:0]      hash_r;
  logic [LEN_W-1:0] len_r;
  logic [127:0]     sym_r;
  logic [63:0]      off_r, size_r;
  logic [31:0]      cks_r, uid_r;

  // Probe control.
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [IDX_W-1:0] step_r, step_nxt;
  logic [IDX_W-1:0] clr_idx_r, clr_idx_nxt;

  // Pending result and output register.
  status_t     res_status_r, res_status_nxt;
  logic [9:0]  res_slot_r, res_slot_nxt;
  entry_t      res_ent_r, res_ent_nxt;
  logic        out_valid_r;
  logic [2:0]  out_status_r;
  logic [9:0]  out_slot_r;
  logic [63:0] out_off_r, out_size_r;
  logic [31:0] out_cks_r, out_uid_r;

  // Memory ports.
  entry_t           mem [DEPTH];
  entry_t           rdata_r;
  logic [IDX_W-1:0] rd_addr;
  logic             we;
  logic [IDX_W-1:0] waddr;
  entry_t           wdata;

  logic             accept, out_free, fin;
  logic [LEN_W-1:0] in_len_c;
  logic [IDX_W-1:0] start_idx, next_idx;
  logic             hit;
  logic [9:0]       mask10;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign fin       = (state_r == S_FIN) && out_free;
  assign in_len_c  = canon_len(in_symbol_length);
  assign start_idx = IDX_W'(in_key_hash) & mask;
  assign next_idx  = (idx_r + 1'b1) & mask;
  assign mask10    = 10'(mask);
  assign hit = rdata_r.valid && (rdata_r.hash == hash_r) && (rdata_r.len == len_r) &&
               (rdata_r.sym == sym_r);

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    step_nxt       = step_r;
    clr_idx_nxt    = clr_idx_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    res_ent_nxt    = res_ent_r;
    rd_addr        = idx_r;
    we             = 1'b0;
    waddr          = idx_r;
    wdata          = rdata_r;
    case (state_r)
      S_INIT, S_CLEAR: begin
        we          = 1'b1;
        waddr       = clr_idx_r;
        wdata       = '0;
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == {IDX_W{1'b1}}) begin
          state_nxt      = (state_r == S_INIT) ? S_IDLE : S_FIN;
          res_status_nxt = ST_OK;
          res_slot_nxt   = '0;
          res_ent_nxt    = '0;
        end
      end
      S_IDLE: begin
        if (accept) begin
          res_slot_nxt = '0;
          res_ent_nxt  = '0;
          step_nxt     = '0;
          case (opcode_t'(in_opcode))
            OP_CLEAR: begin
              clr_idx_nxt = '0;
              state_nxt   = S_CLEAR;
            end
            OP_PATCH: begin
              idx_nxt = IDX_W'(in_target_slot);
              rd_addr = IDX_W'(in_target_slot);
              if ((in_target_slot & ~mask10) != 10'd0) begin
                res_status_nxt = ST_NOT_FOUND;
                state_nxt      = S_FIN;
              end else begin
                state_nxt = S_PATCH;
              end
            end
            default: begin
              idx_nxt = start_idx;
              rd_addr = start_idx;
              if (in_len_c == '0) begin
                res_status_nxt = ST_EMPTY_SYM;
                state_nxt      = S_FIN;
              end else begin
                state_nxt = S_PROBE;
              end
            end
          endcase
        end
      end
      S_PATCH: begin
        state_nxt = S_FIN;
        if (rdata_r.valid) begin
          we             = 1'b1;
          wdata.checksum = cks_r;
          res_status_nxt = ST_OK;
          res_slot_nxt   = 10'(idx_r);
        end else begin
          res_status_nxt = ST_NOT_FOUND;
        end
      end
      S_PROBE: begin
        if (!rdata_r.valid) begin
          state_nxt = S_FIN;
          if (op_r == OP_INSERT) begin
            we = 1'b1;
            wdata = '{valid: 1'b1, hash: hash_r, len: len_r, sym: sym_r,
                      offset: off_r, size: size_r, checksum: cks_r, uid: uid_r};
            res_status_nxt = ST_OK;
            res_slot_nxt   = 10'(idx_r);
          end else begin
            res_status_nxt = ST_NOT_FOUND;
          end
        end else if (hit) begin
          state_nxt    = S_FIN;
          res_slot_nxt = 10'(idx_r);
          if (op_r == OP_INSERT) begin
            res_status_nxt = ST_DUPLICATE;
          end else begin
            res_status_nxt = ST_OK;
            res_ent_nxt    = rdata_r;
          end
        end else if (step_r == mask) begin
          state_nxt      = S_FIN;
          res_status_nxt = (op_r == OP_INSERT) ? ST_FULL : ST_NOT_FOUND;
        end else begin
          idx_nxt  = next_idx;
          rd_addr  = next_idx;
          step_nxt = step_r + 1'b1;
        end
      end
      S_FIN: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      clr_idx_r   <= '0;
      lg_cfg_r    <= LG_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_idx_r <= clr_idx_nxt;
      if (cfg_wr) lg_cfg_r <= pwdata[3:0];
      if (fin) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    idx_r        <= idx_nxt;
    step_r       <= step_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    res_ent_r    <= res_ent_nxt;
    if (accept) begin
      op_r   <= opcode_t'(in_opcode);
      hash_r <= in_key_hash;
      len_r  <= in_len_c;
      sym_r  <= canon_sym(in_len_c, in_symbol_low, in_symbol_high);
      off_r  <= in_entry_offset;
      size_r <= in_entry_size;
      cks_r  <= in_entry_checksum;
      uid_r  <= in_entry_uid;
    end
    if (fin) begin
      out_status_r <= res_status_r;
      out_slot_r   <= res_slot_r;
      out_off_r    <= res_ent_r.offset;
      out_size_r   <= res_ent_r.size;
      out_cks_r    <= res_ent_r.checksum;
      out_uid_r    <= res_ent_r.uid;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_slot_found     = out_slot_r;
  assign out_found_offset   = out_off_r;
  assign out_found_size     = out_size_r;
  assign out_found_checksum = out_cks_r;
  assign out_found_uid      = out_uid_r;

  a_init_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INIT) |-> !in_ready) else $error("request taken during clearing pass");

  a_valid_write_src: assert property (@(posedge clk) disable iff (!rst_n)
    (we && wdata.valid) |-> (state_r == S_PROBE || state_r == S_PATCH))
    else $error("live entry written outside probe or patch");

  a_probe_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PROBE) |-> ((step_r & ~mask) == '0)) else $error("probe ran past a sweep");

  a_fin_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready && state_r == S_FIN) |=> (state_r == S_FIN))
    else $error("result left while output held");

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

// Self-checking bench for the linear probe symbol table. A driver pushes
// request words from a queue, and a shadow copy of the table inside the bench
// works out the answer to each request at the edge where it is accepted. A
// monitor compares every result word with the oldest answer still waiting.
module tb_top;
  import lpst_pkg::*;

  // One request word, as it travels on the input channel.
  typedef struct {
    opcode_t     op;
    logic [63:0] hash;
    logic [4:0]  len;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] offset;
    logic [63:0] size;
    logic [31:0] crc;
    logic [31:0] uid;
    logic [9:0]  tslot;
  } request_t;

  // One result word, as it comes back on the output channel.
  typedef struct {
    logic [2:0]  status;
    logic [9:0]  slot;
    logic [63:0] offset;
    logic [63:0] size;
    logic [31:0] crc;
    logic [31:0] uid;
  } answer_t;

  localparam int STALL_LIMIT = 6000;
  localparam int POOL_N = 16;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_opcode = '0;
  logic [63:0] in_key_hash = '0;
  logic [4:0]  in_symbol_length = '0;
  logic [63:0] in_symbol_low = '0;
  logic [63:0] in_symbol_high = '0;
  logic [63:0] in_entry_offset = '0;
  logic [63:0] in_entry_size = '0;
  logic [31:0] in_entry_checksum = '0;
  logic [31:0] in_entry_uid = '0;
  logic [9:0]  in_target_slot = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_status;
  logic [9:0]  out_slot_found;
  logic [63:0] out_found_offset;
  logic [63:0] out_found_size;
  logic [31:0] out_found_checksum;
  logic [31:0] out_found_uid;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  linear_probe_symbol_table DUT (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  // Shadow copy of the table and of the slot count register.
  logic [3:0]   shadow_lg = LG_RESET;
  bit           shadow_valid [1024];
  logic [63:0]  shadow_hash [1024];
  logic [4:0]   shadow_len [1024];
  logic [127:0] shadow_sym [1024];
  logic [63:0]  shadow_offset [1024];
  logic [63:0]  shadow_size [1024];
  logic [31:0]  shadow_crc [1024];
  logic [31:0]  shadow_uid [1024];

  request_t pending_requests[$];
  answer_t  awaited_results[$];
  request_t word_on_bus;
  int       sender_idle_pct = 0;
  int       receiver_stall_pct = 0;
  int       fail_count = 0;
  int       quiet_cycles = 0;

  // Pool of symbols that the random requests keep coming back to, so that
  // lookups hit and inserts collide. The upper half reuses the hashes of the
  // lower half, which forces long probe chains of different symbols.
  logic [63:0] pool_lo [POOL_N];
  logic [63:0] pool_hi [POOL_N];
  logic [4:0]  pool_len [POOL_N];
  logic [63:0] pool_hash [POOL_N];

  function automatic int slots_now();
    int lg;
    lg = int'(shadow_lg);
    if (lg < int'(LG_MIN)) lg = int'(LG_MIN);
    if (lg > int'(LG_MAX)) lg = int'(LG_MAX);
    return 1 << lg;
  endfunction

  // Appends one request to the tail of the pending queue.
  function automatic void queue_request(request_t r);
    pending_requests.insert(pending_requests.size(), r);
  endfunction

  // Applies one request to the shadow table and returns the result the block
  // must give for it.
  function automatic answer_t apply_to_shadow(request_t r);
    answer_t      a;
    int           n;
    int           idx;
    int           probe;
    logic [4:0]   len;
    logic [127:0] raw;
    logic [127:0] sym;
    logic [7:0]   c;
    bit           done;
    a = '{status: ST_OK, slot: '0, offset: '0, size: '0, crc: '0, uid: '0};
    n = slots_now();
    case (r.op)
      OP_CLEAR: begin
        foreach (shadow_valid[k]) shadow_valid[k] = 1'b0;
      end
      OP_PATCH: begin
        if (r.tslot < n && shadow_valid[r.tslot]) begin
          shadow_crc[r.tslot] = r.crc;
          a.slot = r.tslot;
        end else begin
          a.status = ST_NOT_FOUND;
        end
      end
      default: begin
        // Lengths past sixteen act as sixteen; bytes past the length read
        // as zero and lower-case letters compare as upper case.
        len = (r.len > 5'd16) ? 5'd16 : r.len;
        raw = {r.hi, r.lo};
        sym = '0;
        for (int i = 0; i < 16; i++) begin
          c = raw[i*8 +: 8];
          if (c >= 8'h61 && c <= 8'h7a) c = c - 8'h20;
          if (i < len) sym[i*8 +: 8] = c;
        end
        if (len == 0) begin
          a.status = ST_EMPTY_SYM;
        end else begin
          idx = int'(r.hash[9:0]) & (n - 1);
          done = 1'b0;
          for (probe = 0; probe < n && !done; probe++) begin
            if (!shadow_valid[idx]) begin
              if (r.op == OP_INSERT) begin
                shadow_valid[idx] = 1'b1;
                shadow_hash[idx] = r.hash;
                shadow_len[idx] = len;
                shadow_sym[idx] = sym;
                shadow_offset[idx] = r.offset;
                shadow_size[idx] = r.size;
                shadow_crc[idx] = r.crc;
                shadow_uid[idx] = r.uid;
                a.slot = 10'(idx);
              end else begin
                a.status = ST_NOT_FOUND;
              end
              done = 1'b1;
            end else if (shadow_hash[idx] == r.hash && shadow_len[idx] == len &&
                         shadow_sym[idx] == sym) begin
              a.slot = 10'(idx);
              if (r.op == OP_INSERT) begin
                a.status = ST_DUPLICATE;
              end else begin
                a.offset = shadow_offset[idx];
                a.size = shadow_size[idx];
                a.crc = shadow_crc[idx];
                a.uid = shadow_uid[idx];
              end
              done = 1'b1;
            end else begin
              idx = (idx + 1) & (n - 1);
            end
          end
          // A whole sweep without an empty slot or a match.
          if (!done) a.status = (r.op == OP_INSERT) ? ST_FULL : ST_NOT_FOUND;
        end
      end
    endcase
    return a;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Builds a request around pool symbol idx. With mixed_case set, letters are
  // randomly lowered and bytes past the length are filled with garbage, which
  // must not change which entry the request names.
  function automatic request_t pool_request(opcode_t op, int idx, bit mixed_case);
    request_t     r;
    logic [127:0] raw;
    r.op = op;
    r.hash = pool_hash[idx];
    r.len = pool_len[idx];
    raw = {pool_hi[idx], pool_lo[idx]};
    if (mixed_case) begin
      for (int i = 0; i < 16; i++) begin
        if (i >= pool_len[idx]) raw[i*8 +: 8] = 8'($urandom);
        else if (raw[i*8 +: 8] >= 8'h41 && raw[i*8 +: 8] <= 8'h5a && $urandom_range(1))
          raw[i*8 +: 8] = raw[i*8 +: 8] | 8'h20;
      end
      if (pool_len[idx] == 5'd16 && $urandom_range(1)) r.len = 5'($urandom_range(31, 17));
    end
    {r.hi, r.lo} = raw;
    r.offset = rand64();
    r.size = rand64();
    r.crc = $urandom;
    r.uid = $urandom;
    r.tslot = 10'($urandom);
    return r;
  endfunction

  // Random request: mostly inserts and lookups of pool symbols, with
  // patches, the odd clear, and some words of random noise.
  function automatic request_t random_request();
    request_t r;
    int       pick;
    pick = $urandom_range(99);
    r = pool_request(pick < 45 ? OP_INSERT : OP_LOOKUP, $urandom_range(POOL_N - 1), 1'b1);
    if (pick >= 80 && pick < 94) begin
      r.op = OP_PATCH;
      r.tslot = $urandom_range(3) ? 10'($urandom_range(slots_now() - 1)) : 10'($urandom);
    end else if (pick >= 94 && pick < 96) begin
      r.op = OP_CLEAR;
    end else if (pick >= 96) begin
      r.op = opcode_t'($urandom_range(1));
      r.hash = rand64();
      r.len = 5'($urandom);
      r.lo = rand64();
      r.hi = rand64();
    end
    return r;
  endfunction

  // Driver: presents one word at a time and keeps it steady until taken.
  // The shadow table is updated at the accepting edge, in acceptance order.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        awaited_results.insert(awaited_results.size(), apply_to_shadow(word_on_bus));
      end
      if (!in_valid || in_ready) begin
        if (pending_requests.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          word_on_bus = pending_requests.pop_front();
          in_valid <= 1'b1;
          in_opcode <= word_on_bus.op;
          in_key_hash <= word_on_bus.hash;
          in_symbol_length <= word_on_bus.len;
          in_symbol_low <= word_on_bus.lo;
          in_symbol_high <= word_on_bus.hi;
          in_entry_offset <= word_on_bus.offset;
          in_entry_size <= word_on_bus.size;
          in_entry_checksum <= word_on_bus.crc;
          in_entry_uid <= word_on_bus.uid;
          in_target_slot <= word_on_bus.tslot;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random backpressure, and a field-by-field compare of each
  // result word with the oldest answer waiting.
  always @(posedge clk) begin
    answer_t want;
    out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    if (rst_n && out_valid && out_ready) begin
      if (awaited_results.size() == 0) begin
        $error("result word with no request pending: status %0d", out_status);
        fail_count++;
      end else begin
        want = awaited_results.pop_front();
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          fail_count++;
        end
        if (out_slot_found !== want.slot) begin
          $error("slot_found: expected %0d, got %0d", want.slot, out_slot_found);
          fail_count++;
        end
        if (out_found_offset !== want.offset) begin
          $error("found_offset: expected %h, got %h", want.offset, out_found_offset);
          fail_count++;
        end
        if (out_found_size !== want.size) begin
          $error("found_size: expected %h, got %h", want.size, out_found_size);
          fail_count++;
        end
        if (out_found_checksum !== want.crc) begin
          $error("found_checksum: expected %h, got %h", want.crc, out_found_checksum);
          fail_count++;
        end
        if (out_found_uid !== want.uid) begin
          $error("found_uid: expected %h, got %h", want.uid, out_found_uid);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: the reset pass and a clear each keep both channels quiet while
  // they sweep the whole memory, so the limit sits well above that sweep.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("[linear_probe_symbol_table] ERROR");
      $finish;
    end
  end

  // APB write: setup cycle, then the access cycle. The register takes the
  // value at the edge that closes the access cycle.
  task automatic write_slot_count_log2(logic [3:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'(REG_SLOT_COUNT_LOG2 * 4);
    pwdata <= {28'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    shadow_lg = value;
  endtask

  task automatic drain();
    while (pending_requests.size() > 0 || in_valid || awaited_results.size() > 0)
      @(posedge clk);
  endtask

  // Register settings per random phase, the out-of-range ones included.
  logic [3:0] phase_lg [8] = '{4'd10, 4'd3, 4'd0, 4'd15, 4'd5, 4'd2, 4'd11, 4'd7};

  initial begin
    request_t r;
    for (int i = 0; i < POOL_N; i++) begin
      pool_len[i] = (i % 4 == 0) ? 5'd16 : 5'($urandom_range(16, 1));
      pool_lo[i] = '0;
      pool_hi[i] = '0;
      for (int b = 0; b < 16; b++) begin
        logic [7:0] ch;
        ch = $urandom_range(2) ? 8'($urandom_range(8'h5a, 8'h41)) : 8'($urandom);
        if (b < 8) pool_lo[i][b*8 +: 8] = ch;
        else pool_hi[i][(b-8)*8 +: 8] = ch;
      end
      pool_hash[i] = (i < POOL_N / 2) ? rand64() : pool_hash[i - POOL_N / 2];
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part on the smallest table, eight slots.
    write_slot_count_log2(LG_MIN);
    r = pool_request(OP_CLEAR, 0, 1'b0);
    queue_request(r);
    r = pool_request(OP_INSERT, 1, 1'b0);
    r.len = 5'd0;
    queue_request(r);
    r.op = OP_LOOKUP;
    queue_request(r);
    // Patch of an empty slot.
    r = pool_request(OP_PATCH, 0, 1'b0);
    r.tslot = 10'd0;
    queue_request(r);
    // Fill all eight slots, then one more insert finds the table full and a
    // lookup of an absent symbol sweeps the whole table.
    for (int i = 0; i < 8; i++) queue_request(pool_request(OP_INSERT, i, 1'b0));
    queue_request(pool_request(OP_INSERT, 8, 1'b0));
    queue_request(pool_request(OP_LOOKUP, 9, 1'b0));
    // Duplicate and hit through lower-case spellings.
    queue_request(pool_request(OP_INSERT, 3, 1'b1));
    queue_request(pool_request(OP_LOOKUP, 5, 1'b1));
    r = pool_request(OP_PATCH, 0, 1'b0);
    r.tslot = 10'd2;
    r.crc = '1;
    queue_request(r);
    r.tslot = 10'd9;
    queue_request(r);
    r.tslot = 10'd1023;
    queue_request(r);
    for (int i = 0; i < 8; i++) queue_request(pool_request(OP_LOOKUP, i, 1'b1));
    queue_request(pool_request(OP_CLEAR, 0, 1'b0));
    // All-ones and all-zero words.
    r = '{op: OP_INSERT, hash: '1, len: '1, lo: '1, hi: '1, offset: '1, size: '1,
          crc: '1, uid: '1, tslot: '1};
    queue_request(r);
    r.op = OP_LOOKUP;
    queue_request(r);
    r = '{op: OP_INSERT, hash: '0, len: 5'd1, lo: '0, hi: '0, offset: '0, size: '0,
          crc: '0, uid: '0, tslot: '0};
    queue_request(r);
    r.op = OP_LOOKUP;
    queue_request(r);
    drain();

    // Random phases. Each register setting is run under all four idling
    // patterns in turn; the table is left as it is across register writes.
    for (int p = 0; p < 8; p++) begin
      write_slot_count_log2(phase_lg[p]);
      for (int s = 0; s < 4; s++) begin
        case (s)
          0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
          1: begin sender_idle_pct = 77; receiver_stall_pct = 0;  end
          2: begin sender_idle_pct = 0;  receiver_stall_pct = 77; end
          default: begin sender_idle_pct = 28; receiver_stall_pct = 28; end
        endcase
        for (int i = 0; i < 55; i++) queue_request(random_request());
        drain();
      end
    end
    sender_idle_pct = 0;
    receiver_stall_pct = 0;

    repeat (40) @(posedge clk);
    if (fail_count == 0 && awaited_results.size() == 0) begin
      $display("[linear_probe_symbol_table] OK");
    end else begin
      $display("[linear_probe_symbol_table] ERROR");
    end
    $finish;
  end

endmodule
